@@ design/keyboard_scancode_to_ascii_fifo_top_assert.svh @@
// assertion helpers used by the checker file
`ifndef KEYBOARD_SCANCODE_TO_ASCII_FIFO_TOP_ASSERT_SVH
`define KEYBOARD_SCANCODE_TO_ASCII_FIFO_TOP_ASSERT_SVH

// property checked on every clock edge outside reset
`define KSAF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked on every clock edge, reset included
`define KSAF_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/ksaf_pkg.sv @@
`default_nettype none

package ksaf_pkg;

  localparam int FIFO_DEPTH = 256;
  localparam int PTR_W      = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int KEY_COUNT  = 58;
  localparam int KEY_IDX_W  = $clog2(KEY_COUNT);

  // operation codes
  localparam logic [1:0] OP_SCAN  = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  // special scancodes
  localparam logic [7:0] SC_LSHIFT_MAKE  = 8'h2A;
  localparam logic [7:0] SC_RSHIFT_MAKE  = 8'h36;
  localparam logic [7:0] SC_LSHIFT_BREAK = 8'hAA;
  localparam logic [7:0] SC_RSHIFT_BREAK = 8'hB6;
  localparam logic [7:0] SC_CAPS_LOCK    = 8'h3A;
  localparam logic [7:0] SC_F1           = 8'h3B;

  // unshifted keymap, indexed by make code
  localparam logic [6:0] PLAIN_KEYS [KEY_COUNT] = '{
    7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
    7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09,
    7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
    7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00, 7'h61, 7'h73,
    7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
    7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76,
    7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A,
    7'h00, 7'h20
  };

  // shifted keymap
  localparam logic [6:0] UPPER_KEYS [KEY_COUNT] = '{
    7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E,
    7'h26, 7'h2A, 7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09,
    7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
    7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00, 7'h41, 7'h53,
    7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
    7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56,
    7'h42, 7'h4E, 7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A,
    7'h00, 7'h20
  };

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_SHIFT_SET,
    ACT_SHIFT_CLEAR,
    ACT_CAPS_TOGGLE,
    ACT_DEBUG_SET,
    ACT_CHAR
  } key_action_t;

  typedef struct packed {
    key_action_t action;
    logic [6:0]  ch;
  } key_decode_t;

  typedef logic [PTR_W-1:0] ptr_t;

  function automatic ptr_t ptr_inc(ptr_t p);
    ptr_t r;
    if (p == PTR_W'(FIFO_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ design/ksaf_decode.sv @@
`default_nettype none

module ksaf_decode (
  input  logic                  [7:0] code,
  input  logic                        shift_held,
  input  logic                        caps_active,
  output ksaf_pkg::key_decode_t       decoded
);

  logic [6:0] raw_ch;
  logic [6:0] ch;
  logic       in_table;

  assign in_table = (code < 8'(ksaf_pkg::KEY_COUNT));

  always_comb begin
    raw_ch = 7'h00;
    if (in_table) begin
      if (shift_held) begin
        raw_ch = ksaf_pkg::UPPER_KEYS[code[ksaf_pkg::KEY_IDX_W-1:0]];
      end else begin
        raw_ch = ksaf_pkg::PLAIN_KEYS[code[ksaf_pkg::KEY_IDX_W-1:0]];
      end
    end
  end

  // caps lock swaps letter case
  always_comb begin
    ch = raw_ch;
    if (caps_active && (((raw_ch >= 7'h61) && (raw_ch <= 7'h7A)) ||
                        ((raw_ch >= 7'h41) && (raw_ch <= 7'h5A)))) begin
      ch = raw_ch ^ 7'h20;
    end
  end

  always_comb begin
    decoded.ch = ch;
    priority if (code == ksaf_pkg::SC_LSHIFT_MAKE || code == ksaf_pkg::SC_RSHIFT_MAKE) begin
      decoded.action = ksaf_pkg::ACT_SHIFT_SET;
    end else if (code == ksaf_pkg::SC_LSHIFT_BREAK ||
                 code == ksaf_pkg::SC_RSHIFT_BREAK) begin
      decoded.action = ksaf_pkg::ACT_SHIFT_CLEAR;
    end else if (code == ksaf_pkg::SC_CAPS_LOCK) begin
      decoded.action = ksaf_pkg::ACT_CAPS_TOGGLE;
    end else if (code == ksaf_pkg::SC_F1) begin
      decoded.action = ksaf_pkg::ACT_DEBUG_SET;
    end else if (code[7] || (ch == 7'h00)) begin
      decoded.action = ksaf_pkg::ACT_NONE;
    end else begin
      decoded.action = ksaf_pkg::ACT_CHAR;
    end
  end

endmodule

`default_nettype wire

@@ design/ksaf_ram.sv @@
`default_nettype none

module ksaf_ram (
  input  logic                 clk,
  input  logic                 wr_en,
  input  ksaf_pkg::ptr_t       wr_addr,
  input  logic           [6:0] wr_data,
  input  logic                 rd_en,
  input  ksaf_pkg::ptr_t       rd_addr,
  output logic           [6:0] rd_data
);

  logic [6:0] mem [ksaf_pkg::FIFO_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ design/keyboard_scancode_to_ascii_fifo_top.sv @@
// keyboard scancode to ascii decoder with a character fifo
//
// input channel (in_valid / in_ready) carries one word per item: an operation
// code and a set-1 scancode byte. operation 0 feeds a scancode, 1 pops the
// oldest decoded character, 2 clears the debug request raised by f1.
// output channel (out_valid / out_ready) returns exactly one word per item:
// char_valid, char_out (zero unless a character was popped) and debug_pending.
//
// an accepted word lands in an input register, is decoded and applied to the
// shift, caps, debug and fifo state in one pass, and its result is loaded
// into the output register once that register is free. throughput is one
// word per cycle while the receiver is ready, set by the single decode pass
// and the one fifo ram access per word. when the receiver stalls, the result
// holds and the input register still takes one more word; in_ready drops
// only when both registers are full. the fifo keeps FIFO_DEPTH-1 characters;
// a character arriving when full is dropped. reset (synchronous, active
// high) empties both registers, the fifo pointers and the shift, caps and
// debug flags; ram contents are not cleared.
`default_nettype none

module keyboard_scancode_to_ascii_fifo_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] operation,
  input  logic [7:0] scancode,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       char_valid,
  output logic [6:0] char_out,
  output logic       debug_pending
);

  // input register
  logic       a_valid;
  logic [1:0] a_op;
  logic [7:0] a_code;

  // keyboard and fifo state
  ksaf_pkg::ptr_t write_pointer;
  ksaf_pkg::ptr_t read_pointer;
  ksaf_pkg::ptr_t write_pointer_inc;
  ksaf_pkg::ptr_t read_pointer_inc;
  logic           shift_held;
  logic           caps_active;
  logic           debug_flag;
  logic           debug_flag_next;

  // output register payload
  logic       hit;
  logic [6:0] rd_data;

  logic                  a_moves;
  logic                  fifo_empty;
  logic                  fifo_full;
  logic                  do_write;
  logic                  do_read;
  ksaf_pkg::key_decode_t decoded;
  logic                  is_scan;

  // word leaves the input register when the output register is free
  assign a_moves  = a_valid && (!out_valid || out_ready);
  assign in_ready = !a_valid || a_moves;

  ksaf_decode u_decode (
    .code        (a_code),
    .shift_held  (shift_held),
    .caps_active (caps_active),
    .decoded     (decoded)
  );

  assign write_pointer_inc = ksaf_pkg::ptr_inc(write_pointer);
  assign read_pointer_inc  = ksaf_pkg::ptr_inc(read_pointer);
  assign fifo_empty        = (read_pointer == write_pointer);
  // one slot is kept open so full and empty differ
  assign fifo_full         = (write_pointer_inc == read_pointer);

  assign is_scan  = (a_op == ksaf_pkg::OP_SCAN);
  assign do_write = a_moves && is_scan && (decoded.action == ksaf_pkg::ACT_CHAR) && !fifo_full;
  assign do_read  = a_moves && (a_op == ksaf_pkg::OP_READ) && !fifo_empty;

  ksaf_ram u_ram (
    .clk     (clk),
    .wr_en   (do_write),
    .wr_addr (write_pointer),
    .wr_data (decoded.ch),
    .rd_en   (do_read),
    .rd_addr (read_pointer),
    .rd_data (rd_data)
  );

  // debug flag after this word, shown in the result
  always_comb begin
    debug_flag_next = debug_flag;
    if (is_scan && (decoded.action == ksaf_pkg::ACT_DEBUG_SET)) begin
      debug_flag_next = 1'b1;
    end else if (a_op == ksaf_pkg::OP_CLEAR) begin
      debug_flag_next = 1'b0;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (in_ready) begin
      a_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      a_op   <= operation;
      a_code <= scancode;
    end
  end

  // keyboard state and fifo pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      write_pointer <= '0;
      read_pointer  <= '0;
      shift_held    <= 1'b0;
      caps_active   <= 1'b0;
      debug_flag    <= 1'b0;
    end else begin
      if (do_write) begin
        write_pointer <= write_pointer_inc;
      end
      if (do_read) begin
        read_pointer <= read_pointer_inc;
      end
      if (a_moves) begin
        debug_flag <= debug_flag_next;
        if (is_scan) begin
          unique case (decoded.action)
            ksaf_pkg::ACT_SHIFT_SET:   shift_held  <= 1'b1;
            ksaf_pkg::ACT_SHIFT_CLEAR: shift_held  <= 1'b0;
            ksaf_pkg::ACT_CAPS_TOGGLE: caps_active <= !caps_active;
            default: begin
            end
          endcase
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (a_moves) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (a_moves) begin
      hit           <= do_read;
      debug_pending <= debug_flag_next;
    end
  end

  assign char_valid = hit;
  assign char_out   = hit ? rd_data : 7'h00;

endmodule

`default_nettype wire

@@ design/ksaf_checker.sv @@
`default_nettype none

`include "keyboard_scancode_to_ascii_fifo_top_assert.svh"

module ksaf_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [1:0] operation,
  input  logic [7:0] scancode,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic       char_valid,
  input  logic [6:0] char_out,
  input  logic       debug_pending
);

  property p_char_zero;
    out_valid && !char_valid |-> char_out == 7'h00;
  endproperty

  property p_stall_hold;
    out_valid && !out_ready |=>
      out_valid && $stable(char_valid) && $stable(char_out) && $stable(debug_pending);
  endproperty

  property p_in_hold;
    in_valid && !in_ready |=> in_valid && $stable(operation) && $stable(scancode);
  endproperty

  // no character means a zero character
  `KSAF_ASSERT(a_char_zero, p_char_zero, "char_out set without char_valid")

  // reset empties the output side
  `KSAF_ASSERT_RST(a_rst_clears, rst |=> !out_valid, "result word present after reset")

  // an empty output side never blocks the input
  `KSAF_ASSERT(a_ready_when_empty, !out_valid |-> in_ready, "input blocked with no pending result")

  // a stalled result holds
  `KSAF_ASSERT(a_stall_hold, p_stall_hold, "stalled result word changed")

  // a waiting input word holds
  `KSAF_ASSERT(a_in_hold, p_in_hold, "waiting input word changed")

endmodule

bind keyboard_scancode_to_ascii_fifo_top ksaf_checker u_ksaf_checker (.*);

`default_nettype wire
